/* src/ilt_pkg.sv */
// Shared types and constants for the indent level tracker.
`default_nettype none
package ilt_pkg;
	localparam int STACK_DEPTH = 32;
	localparam int WIDTH_BITS = 8;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	typedef logic [WIDTH_BITS-1:0] width_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		TOK_EQ = 2'd0,
		TOK_GT = 2'd1,
		TOK_LT = 2'd2,
		TOK_ERR = 2'd3
	} tok_kind_t;

	typedef struct packed {
		logic [7:0] indent_width;
		logic [15:0] line_number;
		logic [15:0] column_number;
	} line_word_t;

	typedef struct packed {
		tok_kind_t token_kind;
		logic [15:0] token_line;
		logic [15:0] token_column;
		logic error_seen;
		logic last_of_run;
	} token_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_LOAD,
		ST_CMP,
		ST_EMIT
	} ilt_state_t;

	typedef struct packed {
		logic load;
		logic push;
		logic pop;
		logic rd_en;
		logic set_top;
		logic kind_we;
		tok_kind_t kind;
		logic set_err;
		logic inc_extra;
		logic dec_extra;
	} ilt_cmd_t;

	typedef struct packed {
		logic eq;
		logic gt;
		logic full;
		logic last_level;
		logic w_zero;
		logic mem_eq;
		logic mem_lt;
		logic extra_zero;
	} ilt_status_t;
endpackage
`default_nettype wire

/* src/indent_level_tracker.sv */
// Top level of the indent level tracker.
// Takes one line word at a time and answers with one or more indentation tokens
// (EQ, GT, LT, ERR) whose last word has last_of_run set. Each accepted word goes
// through a decide state and then an emit state that gives one token per cycle
// while token_stall is low; EQ, GT and a push onto a full stack give a single
// token. A dedent reads the width stack memory through one registered read port,
// with a load state and a compare state per stack entry examined, so closing n
// levels gives n tokens once the examination is done. line_stall stays high until
// the last token of the run has been taken.
`default_nettype none
module indent_level_tracker
	import ilt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic line_valid,
	output logic line_stall,
	input wire line_word_t line_word,
	output logic token_valid,
	input wire logic token_stall,
	output token_word_t token_word
);
	ilt_cmd_t cmd;
	ilt_status_t status;

	ilt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.line_valid(line_valid),
		.line_stall(line_stall),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.status(status),
		.cmd(cmd)
	);

	ilt_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.line_word(line_word),
		.cmd(cmd),
		.status(status),
		.token_word(token_word)
	);
endmodule
`default_nettype wire

/* src/ilt_ctrl.sv */
// Control state machine of the indent level tracker.
`default_nettype none
module ilt_ctrl
	import ilt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic line_valid,
	output logic line_stall,
	output logic token_valid,
	input wire logic token_stall,
	input wire ilt_status_t status,
	output ilt_cmd_t cmd
);
	ilt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		line_stall = 1'b1;
		token_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				line_stall = 1'b0;
				if (line_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.kind_we = 1'b1;
				state_d = ST_EMIT;
				priority if (status.eq) begin
					cmd.kind = TOK_EQ;
				end else if (status.gt && status.full) begin
					cmd.kind = TOK_ERR;
					cmd.set_err = 1'b1;
				end else if (status.gt) begin
					cmd.kind = TOK_GT;
					cmd.push = 1'b1;
				end else begin
					cmd.pop = 1'b1;
					if (!status.last_level) begin
						cmd.kind_we = 1'b0;
						state_d = ST_LOAD;
					end else if (status.w_zero) begin
						cmd.kind = TOK_LT;
					end else begin
						cmd.kind = TOK_ERR;
						cmd.set_err = 1'b1;
					end
				end
			end
			ST_LOAD: begin
				cmd.rd_en = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.kind_we = 1'b1;
				state_d = ST_EMIT;
				priority if (status.mem_eq) begin
					cmd.kind = TOK_LT;
					cmd.set_top = 1'b1;
				end else if (status.mem_lt) begin
					cmd.kind = TOK_ERR;
					cmd.set_top = 1'b1;
					cmd.set_err = 1'b1;
				end else begin
					cmd.pop = 1'b1;
					cmd.inc_extra = 1'b1;
					if (!status.last_level) begin
						cmd.kind_we = 1'b0;
						state_d = ST_LOAD;
					end else if (status.w_zero) begin
						cmd.kind = TOK_LT;
					end else begin
						cmd.kind = TOK_ERR;
						cmd.set_err = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				token_valid = 1'b1;
				if (!token_stall) begin
					if (status.extra_zero) begin
						state_d = ST_IDLE;
					end else begin
						cmd.dec_extra = 1'b1;
						cmd.kind_we = 1'b1;
						cmd.kind = TOK_LT;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	ap_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !status.full)
		else $error("push issued on a full stack");
	ap_load_then_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |=> state_q == ST_CMP)
		else $error("stack read not followed by compare");
	ap_accept_then_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(line_valid && !line_stall) |=> state_q == ST_DECIDE)
		else $error("accepted word not decided");
endmodule
`default_nettype wire

/* src/ilt_dp.sv */
// Datapath of the indent level tracker: width stack, counters and token register.
`default_nettype none
module ilt_dp
	import ilt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire line_word_t line_word,
	input wire ilt_cmd_t cmd,
	output ilt_status_t status,
	output token_word_t token_word
);
	width_t stack_mem [STACK_DEPTH];
	count_t count_q;
	count_t extra_q;
	logic err_q;
	width_t top_q;
	width_t w_q;
	width_t rd_q;
	logic [15:0] line_q;
	logic [15:0] col_q;
	tok_kind_t kind_q;
	width_t cur;

	assign cur = (count_q == '0) ? '0 : top_q;

	always_comb begin
		status.eq = (w_q == cur);
		status.gt = (w_q > cur);
		status.full = (count_q == count_t'(STACK_DEPTH));
		status.last_level = (count_q == count_t'(1));
		status.w_zero = (w_q == '0);
		status.mem_eq = (rd_q == w_q);
		status.mem_lt = (rd_q < w_q);
		status.extra_zero = (extra_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			extra_q <= '0;
			err_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + count_t'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - count_t'(1);
			end
			if (cmd.load) begin
				extra_q <= '0;
			end else if (cmd.inc_extra) begin
				extra_q <= extra_q + count_t'(1);
			end else if (cmd.dec_extra) begin
				extra_q <= extra_q - count_t'(1);
			end
			if (cmd.set_err) begin
				err_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= width_t'(line_word.indent_width);
			line_q <= line_word.line_number;
			col_q <= line_word.column_number;
		end
		if (cmd.push) begin
			top_q <= w_q;
		end else if (cmd.set_top) begin
			top_q <= rd_q;
		end
		if (cmd.kind_we) begin
			kind_q <= cmd.kind;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[count_q[ADDR_W-1:0]] <= w_q;
		end
		if (cmd.rd_en) begin
			rd_q <= stack_mem[ADDR_W'(count_q - count_t'(1))];
		end
	end

	assign token_word = '{
		token_kind: kind_q,
		token_line: line_q,
		token_column: col_q,
		error_seen: err_q,
		last_of_run: (extra_q == '0)
	};

	ap_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= count_t'(STACK_DEPTH))
		else $error("stack count out of range");
	ap_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> count_q != '0)
		else $error("pop on an empty stack");
	ap_dec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_extra |-> extra_q != '0)
		else $error("extra token count underflow");
	ap_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared");
endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the indent level tracker: directed, full-stack and random tests.
module tb_top;
	import ilt_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic line_valid = 1'b0;
	logic line_stall;
	line_word_t line_word = '0;
	logic token_valid;
	logic token_stall = 1'b0;
	token_word_t token_word;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	width_t level_stack [STACK_DEPTH];
	int unsigned level_depth = 0;
	logic error_sticky = 1'b0;

	token_word_t expected_tokens [$];
	token_word_t expected_head;
	int unsigned lines_sent = 0;
	int unsigned tokens_checked = 0;
	int unsigned mismatches = 0;
	int unsigned kind_count [4] = '{default: 0};

	indent_level_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.line_valid(line_valid),
		.line_stall(line_stall),
		.line_word(line_word),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_word(token_word)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		token_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic width_t top_width();
		return (level_depth != 0) ? level_stack[level_depth-1] : '0;
	endfunction

	task automatic predict_tokens(input line_word_t word);
		width_t w;
		width_t cur;
		tok_kind_t primary;
		int extra;
		logic failed;
		token_word_t tok;
		w = width_t'(word.indent_width);
		cur = top_width();
		extra = 0;
		failed = 1'b0;
		if (w == cur) begin
			primary = TOK_EQ;
		end else if (w > cur) begin
			if (level_depth >= STACK_DEPTH) begin
				error_sticky = 1'b1;
				primary = TOK_ERR;
			end else begin
				level_stack[level_depth] = w;
				level_depth++;
				primary = TOK_GT;
			end
		end else begin
			level_depth--;
			while (level_depth != 0 && level_stack[level_depth-1] != w) begin
				if (level_stack[level_depth-1] < w) begin
					failed = 1'b1;
					break;
				end
				extra++;
				level_depth--;
			end
			if (!failed && level_depth == 0 && w != 0)
				failed = 1'b1;
			if (failed) begin
				error_sticky = 1'b1;
				primary = TOK_ERR;
			end else begin
				primary = TOK_LT;
			end
		end
		for (int k = 0; k <= extra; k++) begin
			tok.token_kind = (k == 0) ? primary : TOK_LT;
			tok.token_line = word.line_number;
			tok.token_column = word.column_number;
			tok.error_seen = error_sticky;
			tok.last_of_run = (k == extra);
			expected_tokens.insert(expected_tokens.size(), tok);
		end
	endtask

	task automatic send_line(input width_t w, input logic [15:0] ln, input logic [15:0] col);
		line_word_t word;
		word.indent_width = w;
		word.line_number = ln;
		word.column_number = col;
		while ($urandom_range(99) < send_idle_pct) begin
			line_valid = 1'b0;
			@(negedge clk);
		end
		line_valid = 1'b1;
		line_word = word;
		@(posedge clk);
		while (line_stall)
			@(posedge clk);
		predict_tokens(word);
		lines_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		line_valid = 1'b0;
		while (expected_tokens.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [15:0] random_coord();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic compare_field(input string name, input logic [15:0] exp_val,
		input logic [15:0] act_val);
		if (exp_val !== act_val) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) begin
			if (expected_tokens.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected token word, expected none, got %h", $time, token_word);
			end else begin
				expected_head = expected_tokens[0];
				expected_tokens.delete(0);
				compare_field("token_kind", 16'(expected_head.token_kind),
					16'(token_word.token_kind));
				compare_field("token_line", expected_head.token_line, token_word.token_line);
				compare_field("token_column", expected_head.token_column,
					token_word.token_column);
				compare_field("error_seen", 16'(expected_head.error_seen),
					16'(token_word.error_seen));
				compare_field("last_of_run", 16'(expected_head.last_of_run),
					16'(token_word.last_of_run));
				tokens_checked++;
				kind_count[expected_head.token_kind]++;
			end
		end
	end

	task automatic test_directed();
		send_line(8'd0, 16'h0000, 16'h0000);
		send_line(8'd4, 16'hFFFF, 16'hFFFF);
		send_line(8'd4, 16'h0001, 16'h8000);
		send_line(8'd8, 16'h5555, 16'hAAAA);
		send_line(8'd255, 16'hAAAA, 16'h5555);
		send_line(8'd4, 16'h0010, 16'h0004);
		send_line(8'd0, 16'h0011, 16'h0000);
		send_line(8'd2, 16'h0012, 16'h0002);
		send_line(8'd6, 16'h0013, 16'h0006);
		// dedent to a width between two open levels
		send_line(8'd4, 16'h0014, 16'h0004);
		// dedent past the bottom with a nonzero width
		send_line(8'd1, 16'h0015, 16'h0001);
		send_line(8'd0, 16'h0016, 16'h0000);
		send_line(8'd170, 16'h0017, 16'h00AA);
		send_line(8'd85, 16'h0018, 16'h0055);
		send_line(8'd0, 16'hFFFE, 16'h0001);
	endtask

	task automatic test_full_stack();
		for (int i = 1; i <= STACK_DEPTH; i++)
			send_line(width_t'(7 * i), 16'(100 + i), 16'(7 * i));
		// push onto a full stack
		send_line(8'd255, 16'h0200, 16'h00FF);
		send_line(width_t'(7 * STACK_DEPTH), 16'h0201, 16'h00E0);
		// end of input closes every level
		send_line(8'd0, 16'hFFFF, 16'h0000);
	endtask

	task automatic test_random(input int unsigned n_items);
		int unsigned push_pct;
		int unsigned run_left;
		int unsigned r;
		width_t cur;
		width_t w;
		run_left = 0;
		push_pct = 25;
		repeat (n_items) begin
			if (run_left == 0) begin
				run_left = $urandom_range(5, 40);
				push_pct = ($urandom_range(1) != 0) ? 75 : 25;
			end
			run_left--;
			cur = top_width();
			r = $urandom_range(99);
			if (r < push_pct) begin
				w = (cur > 8'd248) ? cur : cur + width_t'($urandom_range(1, 7));
			end else if (r < push_pct + (100 - push_pct) / 3) begin
				w = cur;
			end else if (level_depth != 0 && r < 90) begin
				if ($urandom_range(3) == 0)
					w = width_t'($urandom_range(cur));
				else
					w = level_stack[$urandom_range(level_depth - 1)];
			end else if (r < 95) begin
				w = '0;
			end else begin
				w = width_t'($urandom_range(255));
			end
			send_line(w, random_coord(), random_coord());
			if ($urandom_range(49) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		drain();

		send_idle_pct = 7;
		recv_stall_pct = 7;
		test_full_stack();
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(75);
		drain();

		send_idle_pct = 88;
		recv_stall_pct = 0;
		test_random(75);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 88;
		test_random(75);
		drain();

		send_idle_pct = 7;
		recv_stall_pct = 7;
		test_random(75);
		drain();

		repeat (2 * STACK_DEPTH + 16) @(negedge clk);

		$display("tb_top: %0d line words sent, %0d tokens checked", lines_sent, tokens_checked);
		$display("tb_top: %0d EQ, %0d GT, %0d LT, %0d ERR; covered bad dedents, %s",
			kind_count[TOK_EQ], kind_count[TOK_GT], kind_count[TOK_LT],
			kind_count[TOK_ERR], "full-stack push, full close and idle/stall mixes");
		if (mismatches == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	initial begin
		#12000000;
		$display("tb_top: timeout");
		$display("tb_top: done, errors");
		$finish;
	end
endmodule
